// ===== design/pair_run_length_encoder_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Pair run-length encoder assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef PAIR_RUN_LENGTH_ENCODER_UNIT_MACROS_SVH
`define PAIR_RUN_LENGTH_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication.
`define PRLE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication.
`define PRLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== design/prle_pkg.sv =====
// ----------------------------------------------------------------------------
// Pair run-length encoder package
// Shared types and constants for the encoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package prle_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam logic [BYTE_W-1:0] RUN_MAX = 8'd255;
	localparam logic [BYTE_W-1:0] RUN_ONE = 8'd1;

	// kind codes
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] second_byte;
		logic [BYTE_W-1:0] first_byte;
	} pair_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] first_byte;
		logic [BYTE_W-1:0] second_byte;
		logic [BYTE_W-1:0] count;
	} triple_t;

	typedef struct packed {
		logic    load;
		triple_t triple;
	} emit_req_t;

	typedef enum logic [1:0] {
		SEL_FIRST,
		SEL_SECOND,
		SEL_COUNT
	} byte_sel_t;

endpackage

`default_nettype wire

// ===== design/prle_run_tracker.sv =====
// ----------------------------------------------------------------------------
// Pair run-length encoder run tracker
// Holds the current pair and run count; decides when a triple goes out.
// ----------------------------------------------------------------------------
`default_nettype none

module prle_run_tracker (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   item_valid,
	input  wire prle_pkg::pair_item_t   item,
	input  wire logic                   emit_ready,
	output logic                        item_fire,
	output prle_pkg::emit_req_t         emit_req
);
	import prle_pkg::*;

	`include "pair_run_length_encoder_unit_macros.svh"

	logic [BYTE_W-1:0] held_first_q;
	logic [BYTE_W-1:0] held_second_q;
	logic [BYTE_W-1:0] run_count_q;
	logic              holding_q;
	logic              same_pair;
	logic              emit;

	assign same_pair = (item.first_byte == held_first_q) &&
		(item.second_byte == held_second_q);

	// run breaks on end, on a new pair, or on a full count
	assign emit = holding_q &&
		((item.kind == KIND_END) || !same_pair || (run_count_q == RUN_MAX));

	assign item_fire = item_valid && (!emit || emit_ready);

	always_comb begin
		emit_req.load               = item_fire && emit;
		emit_req.triple.first_byte  = held_first_q;
		emit_req.triple.second_byte = held_second_q;
		emit_req.triple.count       = run_count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_first_q  <= '0;
			held_second_q <= '0;
			run_count_q   <= '0;
			holding_q     <= 1'b0;
		end else if (item_fire) begin
			if (item.kind == KIND_END) begin
				held_first_q  <= '0;
				held_second_q <= '0;
				run_count_q   <= '0;
				holding_q     <= 1'b0;
			end else if (!holding_q || emit) begin
				held_first_q  <= item.first_byte;
				held_second_q <= item.second_byte;
				run_count_q   <= RUN_ONE;
				holding_q     <= 1'b1;
			end else begin
				run_count_q <= run_count_q + RUN_ONE;
			end
		end
	end

	`PRLE_ASSERT_NOW(a_count_nonzero, clk, arst_n, holding_q, run_count_q != '0)
	`PRLE_ASSERT_NOW(a_no_emit_idle, clk, arst_n, !holding_q, !emit_req.load)
	`PRLE_ASSERT_NEXT(a_data_holds, clk, arst_n,
		item_fire && (item.kind == KIND_DATA), holding_q)

endmodule

`default_nettype wire

// ===== design/prle_triple_emitter.sv =====
// ----------------------------------------------------------------------------
// Pair run-length encoder triple emitter
// Registers one triple and sends it out one byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module prle_triple_emitter (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire prle_pkg::emit_req_t         emit_req,
	output logic                             emit_ready,
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [prle_pkg::BYTE_W-1:0]      m_axis_tdata,
	output logic                             m_axis_tlast
);
	import prle_pkg::*;

	`include "pair_run_length_encoder_unit_macros.svh"

	triple_t   triple_q;
	byte_sel_t sel_q;
	logic      valid_q;
	logic      take;
	logic      done;

	assign take       = valid_q && m_axis_tready;
	assign done       = take && (sel_q == SEL_COUNT);
	assign emit_ready = !valid_q || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= SEL_FIRST;
		end else if (emit_req.load) begin
			valid_q <= 1'b1;
			sel_q   <= SEL_FIRST;
		end else if (done) begin
			valid_q <= 1'b0;
			sel_q   <= SEL_FIRST;
		end else if (take) begin
			case (sel_q)
				SEL_FIRST:  sel_q <= SEL_SECOND;
				SEL_SECOND: sel_q <= SEL_COUNT;
				default:    sel_q <= SEL_FIRST;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit_req.load) begin
			triple_q <= emit_req.triple;
		end
	end

	always_comb begin
		case (sel_q)
			SEL_FIRST:  m_axis_tdata = triple_q.first_byte;
			SEL_SECOND: m_axis_tdata = triple_q.second_byte;
			SEL_COUNT:  m_axis_tdata = triple_q.count;
			default:    m_axis_tdata = triple_q.count;
		endcase
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tlast  = (sel_q == SEL_COUNT);

	`PRLE_ASSERT_NEXT(a_load_starts, clk, arst_n, emit_req.load,
		valid_q && (sel_q == SEL_FIRST))
	`PRLE_ASSERT_NEXT(a_done_empties, clk, arst_n, done && !emit_req.load, !valid_q)
	`PRLE_ASSERT_NEXT(a_mid_advances, clk, arst_n,
		take && (sel_q != SEL_COUNT), valid_q && (sel_q != SEL_FIRST))

endmodule

`default_nettype wire

// ===== design/pair_run_length_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// Pair run-length encoder
// Encodes a stream of byte pairs into (first, second, count) byte triples.
// ----------------------------------------------------------------------------
// Each input transaction carries one byte pair (tuser low = data) or an
// end-of-stream marker (tuser high, tdata ignored). Repeats of the held pair
// extend the run up to a count of 255; a different pair, a full run or an end
// marker sends the held run out as three byte transactions: first byte,
// second byte, then the count with tlast set. An end marker with no pair held
// sends nothing and the next pair starts a fresh stream. A pair that only
// extends a run never waits on the output, so input transactions may follow
// back to back. Each run break sends one triple over the single byte-wide
// output port, one byte per transaction; a pair that breaks a run waits
// until the emitter is empty or is taking the count byte of the previous
// triple. An accepted pair goes through the input register and the run
// tracker, and each held run goes out through the triple register.
// ----------------------------------------------------------------------------
`default_nettype none

module pair_run_length_encoder_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [7:0] first_byte, [15:8] second_byte
	input  wire logic        s_axis_tuser,  // [0] kind: 0 = pair, 1 = end of stream
	// output stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [7:0] out_byte
	output logic             m_axis_tlast   // last_of_triple
);
	import prle_pkg::*;

	// input register stage
	pair_item_t item_s1;
	logic       valid_s1;
	logic       fire_s1;
	logic       emit_ready;
	emit_req_t  emit_req;
	logic       in_take;

	// the register takes a new transaction when empty or draining this cycle
	assign s_axis_tready = !valid_s1 || fire_s1;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.kind        <= s_axis_tuser;
			item_s1.first_byte  <= s_axis_tdata[7:0];
			item_s1.second_byte <= s_axis_tdata[15:8];
		end
	end

	// run state and break decision
	prle_run_tracker u_tracker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item       (item_s1),
		.emit_ready (emit_ready),
		.item_fire  (fire_s1),
		.emit_req   (emit_req)
	);

	// triple register and byte serializer
	prle_triple_emitter u_emitter (
		.clk           (clk),
		.arst_n        (arst_n),
		.emit_req      (emit_req),
		.emit_ready    (emit_ready),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire
